// ----- hdl/cicmd_pkg.sv -----
`timescale 1ns / 1ps

package cicmd_pkg;

    // Mesh geometry.
    localparam int MESH_SIDE        = 64;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int CELL_W           = $clog2(MESH_SIDE);
    localparam int ADDR_W           = 3 * CELL_W;
    localparam int CELL_COUNT       = MESH_SIDE * MESH_SIDE * MESH_SIDE;
    localparam int AXES             = 3;
    localparam int CORNERS          = 8;
    localparam int CORNER_W         = $clog2(CORNERS);

    // Field widths.
    localparam int POS_W   = 32;
    localparam int INV_W   = 32;
    localparam int TOTAL_W = 40;
    localparam int ECHO_W  = 18;

    // Reset value of the inverse cell length: 1.0 in 16.16.
    localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

    // Request codes.
    localparam logic REQ_DEPOSIT = 1'b0;
    localparam logic REQ_READ    = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [ECHO_W-1:0] read_cell;
    } t_in_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] cell_total;
        logic [ECHO_W-1:0]  cell_echo;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_RECIP,
        ST_SPLIT,
        ST_DEPOSIT,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_READ_WAIT,
        ST_READ_DATA
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                corner_en;
        logic [CORNER_W-1:0] corner;
        logic                rd_issue;
        logic                out_load;
        logic                clr_en;
        logic [ADDR_W-1:0]   clr_addr;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/cicmd_ctrl.sv -----
`timescale 1ns / 1ps

module cicmd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_ready,
    output cicmd_pkg::t_cmd   o_cmd,
    input  cicmd_pkg::t_sts   i_sts
);
    import cicmd_pkg::*;

    localparam logic [ADDR_W-1:0]   CLR_LAST    = ADDR_W'(CELL_COUNT - 1);
    localparam logic [CORNER_W-1:0] CORNER_LAST = CORNER_W'(CORNERS - 1);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [CORNER_W-1:0] r_corner, n_corner;

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_corner <= n_corner;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_corner   = r_corner;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en   = 1'b1;
                o_cmd.clr_addr = r_clr;
                if (r_clr == CLR_LAST) begin
                    n_clr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE, ST_DRAIN2: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_req_type == REQ_READ) ? ST_READ_WAIT : ST_SCALE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCALE: begin
                n_state = ST_RECIP;
            end
            ST_RECIP: begin
                n_state = ST_SPLIT;
            end
            ST_SPLIT: begin
                n_corner = '0;
                n_state  = ST_DEPOSIT;
            end
            ST_DEPOSIT: begin
                o_cmd.corner_en = 1'b1;
                o_cmd.corner    = r_corner;
                if (r_corner == CORNER_LAST) begin
                    n_state = ST_DRAIN1;
                end else begin
                    n_corner = r_corner + 1'b1;
                end
            end
            ST_DRAIN1: begin
                n_state = ST_DRAIN2;
            end
            ST_READ_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = ST_READ_DATA;
                end
            end
            ST_READ_DATA: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/cicmd_datapath.sv -----
`timescale 1ns / 1ps

module cicmd_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cicmd_pkg::t_in_item          i_in_item,
    input  logic                         i_cfg_we,
    input  logic [cicmd_pkg::INV_W-1:0]  i_cfg_data,
    input  cicmd_pkg::t_cmd              i_cmd,
    output cicmd_pkg::t_sts              o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output cicmd_pkg::t_out_item         o_out_item
);
    import cicmd_pkg::*;

    localparam int F      = WEIGHT_FRAC_BITS;
    localparam int WT_W   = F + 1;
    localparam int PROD_W = 2 * WT_W;
    localparam int Q16_W  = 17;
    localparam int Q_DN   = (F >= 16) ? F - 16 : 0;
    localparam int Q_UP   = (F < 16) ? 16 - F : 0;
    localparam int P_W    = 2 * POS_W;
    // Reciprocal for the exact wrap of a 32-bit cell number by the mesh side.
    localparam int SHIFT  = POS_W + CELL_W;
    localparam int RCP_W  = POS_W + 1;
    localparam int MUL_W  = POS_W + RCP_W;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(MESH_SIDE) - 64'd1) / 64'(MESH_SIDE);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP64);
    localparam logic [WT_W-1:0]  WONE  = WT_W'(1) << F;
    localparam logic [CELL_W-1:0] SIDE_LAST = CELL_W'(MESH_SIDE - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Bring a weight to 16 fraction bits.
    function automatic logic [Q16_W-1:0] to_q16(input logic [WT_W-1:0] w);
        logic [WT_W+Q_UP-1:0] t;
        t = (WT_W + Q_UP)'(w) >> Q_DN;
        t = t << Q_UP;
        return Q16_W'(t);
    endfunction

    t_in_item            r_item;
    logic [INV_W-1:0]    r_inv;
    logic [POS_W-1:0]    pos [AXES];
    logic [P_W-1:0]      r_p [AXES];
    logic [POS_W-1:0]    r_q [AXES];
    logic [CELL_W-1:0]   r_lo_cell [AXES];
    logic [CELL_W-1:0]   r_hi_cell [AXES];
    logic [WT_W-1:0]     r_lo_w [AXES];
    logic [WT_W-1:0]     r_hi_w [AXES];

    logic [CELL_W-1:0]   sel_cell [AXES];
    logic [WT_W-1:0]     sel_w [AXES];
    logic [ADDR_W-1:0]   corner_addr;

    logic                r_s1_vld;
    logic [PROD_W-1:0]   r_s1_wxy;
    logic [WT_W-1:0]     r_s1_wz;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic                r_s2_vld;
    logic [PROD_W-1:0]   r_s2_w;
    logic [ADDR_W-1:0]   r_s2_addr;

    logic [TOTAL_W-1:0]  mem [CELL_COUNT];
    logic [ADDR_W-1:0]   rd_addr;
    logic [TOTAL_W-1:0]  r_rdata;
    logic [Q16_W-1:0]    add_w;
    logic [TOTAL_W:0]    sum;
    logic [TOTAL_W-1:0]  wdata;
    logic                in_range;

    logic                r_out_valid;
    t_out_item           r_out_item;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= INV_RESET;
        end else if (i_cfg_we) begin
            r_inv <= i_cfg_data;
        end
    end

    // Item capture on transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
    end

    assign pos[0] = r_item.pos_x;
    assign pos[1] = r_item.pos_y;
    assign pos[2] = r_item.pos_z;

    // Axis lanes: scale, reciprocal quotient, then cell and weights.
    always_ff @(posedge i_clk) begin
        for (int ax = 0; ax < AXES; ax++) begin
            r_p[ax] <= P_W'(pos[ax]) * P_W'(r_inv);
            r_q[ax] <= POS_W'((MUL_W'(r_p[ax][P_W-1:POS_W]) * MUL_W'(RECIP)) >> SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ax = 0; ax < AXES; ax++) begin
            logic [POS_W-1:0]  rem;
            logic [CELL_W-1:0] lo;
            rem = r_p[ax][P_W-1:POS_W] - POS_W'(r_q[ax] * POS_W'(MESH_SIDE));
            lo  = CELL_W'(rem);
            r_lo_cell[ax] <= lo;
            r_hi_cell[ax] <= (lo == SIDE_LAST) ? '0 : lo + 1'b1;
            r_hi_w[ax]    <= WT_W'(r_p[ax][POS_W-1 -: F]);
            r_lo_w[ax]    <= WONE - WT_W'(r_p[ax][POS_W-1 -: F]);
        end
    end

    // Corner selection: x from the top corner bit, z from the bottom one.
    always_comb begin
        for (int ax = 0; ax < AXES; ax++) begin
            if (i_cmd.corner[AXES-1-ax]) begin
                sel_cell[ax] = r_hi_cell[ax];
                sel_w[ax]    = r_hi_w[ax];
            end else begin
                sel_cell[ax] = r_lo_cell[ax];
                sel_w[ax]    = r_lo_w[ax];
            end
        end
        corner_addr = ADDR_W'((ADDR_W'(sel_cell[0]) * ADDR_W'(MESH_SIDE) + ADDR_W'(sel_cell[1]))
                              * ADDR_W'(MESH_SIDE)) + ADDR_W'(sel_cell[2]);
    end

    // Weight pipeline alongside the memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.corner_en;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_wxy  <= PROD_W'(sel_w[0]) * PROD_W'(sel_w[1]);
        r_s1_wz   <= sel_w[2];
        r_s1_addr <= corner_addr;
        r_s2_w    <= PROD_W'(WT_W'(r_s1_wxy >> F)) * PROD_W'(r_s1_wz);
        r_s2_addr <= r_s1_addr;
    end

    // Saturating accumulate of the corner weight.
    assign add_w = to_q16(WT_W'(r_s2_w >> F));
    assign sum   = {1'b0, r_rdata} + (TOTAL_W + 1)'(add_w);
    assign wdata = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    assign rd_addr = i_cmd.rd_issue ? ADDR_W'(r_item.read_cell) : r_s1_addr;

    // Density mesh: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            mem[i_cmd.clr_addr] <= '0;
        end else if (r_s2_vld) begin
            mem[r_s2_addr] <= wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    // Result register.
    assign in_range = (64'(r_item.read_cell) < 64'(CELL_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.cell_total <= in_range ? r_rdata : '0;
            r_out_item.cell_echo  <= r_item.read_cell;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;

endmodule

// ----- hdl/cic_mass_deposit_3d_unit.sv -----
`timescale 1ns / 1ps

// Cloud-in-cell deposit onto a periodic cubic density mesh.
// Input channel (i_in_valid / o_in_ready, i_in_item): a deposit transfer
// adds the eight corner weights of one particle to the mesh and gives no
// result; a read transfer returns one cell total on the output channel
// (o_out_valid / i_out_ready, o_out_item).
// A deposit occupies the block from its transfer to the next possible
// transfer: scaling and cell wrap per axis in the SCALE, RECIP and SPLIT
// states, then eight read-modify-writes on the mesh memory, one corner per
// cycle, and the DRAIN1 and DRAIN2 states for the last write-back to land.
// A read waits until the output register is free, then its cell total goes
// through the registered mesh read port into the output register, and the
// block then takes the next item.
// Reset sets the inverse cell length to 1.0 and clears all MESH_SIDE cubed
// cells of the mesh (262144 at a side of 64), one cell per cycle, with
// o_in_ready low; configuration writes are taken throughout.
// When the receiver stalls, the result stays in the output register and
// deposits are still taken; a further read waits until the result is taken.
module cic_mass_deposit_3d_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  cicmd_pkg::t_in_item          i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output cicmd_pkg::t_out_item         o_out_item,
    input  logic                         i_cfg_we,
    input  logic [cicmd_pkg::INV_W-1:0]  i_cfg_data
);
    import cicmd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    cicmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Axis lanes, weight pipeline, mesh memory and result register.
    cicmd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- verif/cic_deposit_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the configuration port, keeps its own copy of the
// density mesh and the inverse cell length, and compares each returned cell
// total with the oldest outstanding read.
module cic_deposit_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  cicmd_pkg::t_in_item          i_in_item,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  cicmd_pkg::t_out_item         i_out_item,
    input  logic                         i_cfg_we,
    input  logic [cicmd_pkg::INV_W-1:0]  i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import cicmd_pkg::*;

    localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;
    localparam longint unsigned UNIT      = 64'd1 << WEIGHT_FRAC_BITS;

    // Predicted mesh; a cell with no entry has never been deposited into.
    bit [TOTAL_W-1:0] mesh_density [int];
    logic [INV_W-1:0] inv_length = INV_RESET;
    t_out_item        expected_totals [$];
    int               mismatches = 0;
    int               reads_waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = reads_waiting;

    // One line per mismatch, and every one is counted.
    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit [TOTAL_W-1:0] stored_total(input int cell_idx);
        if (cell_idx < CELL_COUNT && mesh_density.exists(cell_idx)) begin
            return mesh_density[cell_idx];
        end
        return '0;
    endfunction

    // Scale one coordinate, wrap its cell and split the fraction into the
    // lower and upper weights.
    function automatic void scale_axis(input logic [POS_W-1:0] pos,
                                       output int lo_cell, output int hi_cell,
                                       output longint unsigned lo_w,
                                       output longint unsigned hi_w);
        longint unsigned scaled;
        longint unsigned frac;
        scaled  = 64'(pos) * 64'(inv_length);
        frac    = (scaled >> (32 - WEIGHT_FRAC_BITS)) & (UNIT - 64'd1);
        lo_cell = int'((scaled >> 32) % 64'(MESH_SIDE));
        hi_cell = (lo_cell + 1) % MESH_SIDE;
        lo_w    = UNIT - frac;
        hi_w    = frac;
    endfunction

    // Bring a weight to 16 fraction bits, truncating when it has more.
    function automatic longint unsigned to_q16(input longint unsigned w);
        if (WEIGHT_FRAC_BITS >= 16) begin
            return w >> (WEIGHT_FRAC_BITS - 16);
        end
        return w << (16 - WEIGHT_FRAC_BITS);
    endfunction

    // Add the eight corner weights of one particle, saturating each cell.
    function automatic void deposit_particle(input t_in_item item);
        int              cx [2];
        int              cy [2];
        int              cz [2];
        longint unsigned wx [2];
        longint unsigned wy [2];
        longint unsigned wz [2];
        longint unsigned w;
        longint unsigned sum;
        int              cell_idx;
        scale_axis(item.pos_x, cx[0], cx[1], wx[0], wx[1]);
        scale_axis(item.pos_y, cy[0], cy[1], wy[0], wy[1]);
        scale_axis(item.pos_z, cz[0], cz[1], wz[0], wz[1]);
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                for (int c = 0; c < 2; c++) begin
                    w        = (wx[a] * wy[b]) >> WEIGHT_FRAC_BITS;
                    w        = (w * wz[c]) >> WEIGHT_FRAC_BITS;
                    cell_idx = (cx[a] * MESH_SIDE + cy[b]) * MESH_SIDE + cz[c];
                    sum      = 64'(stored_total(cell_idx)) + to_q16(w);
                    if (sum > TOTAL_MAX) begin
                        sum = TOTAL_MAX;
                    end
                    mesh_density[cell_idx] = sum[TOTAL_W-1:0];
                end
            end
        end
    endfunction

    // Results are checked before this cycle's request is predicted, so a
    // stray result can never match a read taken in the same cycle.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            mesh_density.delete();
            expected_totals.delete();
            inv_length = INV_RESET;
        end else begin
            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (expected_totals.size() == 0) begin
                    report_error($sformatf("result with no read outstanding: cell %0d total %0h",
                                           i_out_item.cell_echo, i_out_item.cell_total));
                end else begin
                    want = expected_totals.pop_front();
                    if (i_out_item.cell_total !== want.cell_total) begin
                        report_error($sformatf("cell %0d: total %0h, expected %0h",
                                               want.cell_echo, i_out_item.cell_total,
                                               want.cell_total));
                    end
                    if (i_out_item.cell_echo !== want.cell_echo) begin
                        report_error($sformatf("cell echo %0d, expected %0d",
                                               i_out_item.cell_echo, want.cell_echo));
                    end
                end
            end
            if (i_cfg_we === 1'b1) begin
                inv_length = i_cfg_data;
            end
            if (i_in_valid === 1'b1 && i_in_ready === 1'b1) begin
                if (i_in_item.req_type == REQ_READ) begin
                    want.cell_total = stored_total(int'(i_in_item.read_cell));
                    want.cell_echo  = i_in_item.read_cell;
                    expected_totals.push_back(want);
                end else begin
                    deposit_particle(i_in_item);
                end
            end
        end
        reads_waiting = expected_totals.size();
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the cloud-in-cell deposit unit; all checking is
// done by the checker instance beside the block.
module tb;
    import cicmd_pkg::*;

    localparam int RESET_CYCLES   = 8;
    // Covers the time that a deposit keeps the block busy after its transfer.
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_ITEMS  = 100;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_in_item           in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_item          out_item;
    logic               cfg_we    = 1'b0;
    logic [INV_W-1:0]   cfg_data  = '0;
    int                 fail_count;
    int                 pending;

    // Stimulus state: current setting, idling odds and a particle neighbourhood.
    logic [INV_W-1:0]   inv_now       = INV_RESET;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;
    int                 holdoff_req   = 0;
    int                 holdoff_seen  = 0;
    int                 holdoff_left  = 0;
    logic [POS_W-1:0]   base_x        = '0;
    logic [POS_W-1:0]   base_y        = '0;
    logic [POS_W-1:0]   base_z        = '0;

    int                 idle_plan  [4] = '{0, 63, 0, 13};
    int                 stall_plan [4] = '{0, 0, 63, 13};
    logic [INV_W-1:0]   inv_plan   [SEGMENTS] = '{32'h0001_0000, 32'h0040_0000,
                                                  32'hFFFF_FFFF, 32'h0000_0000,
                                                  32'h0001_0000, 32'h0000_0000,
                                                  32'h0000_0001, 32'h0001_8000};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cic_mass_deposit_3d_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    cic_deposit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, and a long hold-off whenever one is requested.
    always @(negedge clk) begin
        if (holdoff_req != holdoff_seen) begin
            holdoff_seen = holdoff_req;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one item, after a random gap, and return at the falling edge
    // after its transfer; valid is left high for a following item.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_ready !== 1'b1) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Stop offering, wait for every outstanding read, then let the last
    // deposit finish its write-backs.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_inv(input logic [INV_W-1:0] value);
        inv_now  = value;
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic t_in_item deposit_req(input logic [POS_W-1:0] x,
                                             input logic [POS_W-1:0] y,
                                             input logic [POS_W-1:0] z);
        t_in_item item;
        item.req_type  = REQ_DEPOSIT;
        item.pos_x     = x;
        item.pos_y     = y;
        item.pos_z     = z;
        item.read_cell = ECHO_W'($urandom);
        return item;
    endfunction

    function automatic t_in_item read_req(input int unsigned cell_idx);
        t_in_item item;
        item.req_type  = REQ_READ;
        item.pos_x     = $urandom;
        item.pos_y     = $urandom;
        item.pos_z     = $urandom;
        item.read_cell = ECHO_W'(cell_idx);
        return item;
    endfunction

    function automatic int unsigned cell_index(input int i, input int j, input int k);
        return (i * MESH_SIDE + j) * MESH_SIDE + k;
    endfunction

    // Lower cell of a coordinate under the current setting, moved on by step.
    function automatic int axis_cell(input logic [POS_W-1:0] pos, input int step);
        return (int'(((64'(pos) * 64'(inv_now)) >> 32) % 64'(MESH_SIDE)) + step) % MESH_SIDE;
    endfunction

    // One of the eight cells that a particle at the base position touches.
    function automatic int unsigned cell_near_base();
        return cell_index(axis_cell(base_x, $urandom_range(1)),
                          axis_cell(base_y, $urandom_range(1)),
                          axis_cell(base_z, $urandom_range(1)));
    endfunction

    // Mostly deposits clustered round a base position, so that cells build
    // up totals, with reads of those cells and some fully random traffic.
    task automatic random_item();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30) begin
            if ($urandom_range(3) == 0) begin
                send_item(read_req($urandom_range(CELL_COUNT - 1)));
            end else begin
                send_item(read_req(cell_near_base()));
            end
        end else if (roll < 42) begin
            base_x = $urandom;
            base_y = $urandom;
            base_z = $urandom;
            send_item(deposit_req(base_x, base_y, base_z));
        end else if (roll < 57) begin
            send_item(deposit_req($urandom, $urandom, $urandom));
        end else begin
            send_item(deposit_req(base_x ^ POS_W'($urandom_range(1023)),
                                  base_y ^ POS_W'($urandom_range(1023)),
                                  base_z ^ POS_W'($urandom_range(1023))));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Unit cell length: origin, half-cell offsets wrapping at the far
        // face, the largest position, and positions well outside the box.
        send_item(deposit_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_item(read_req(cell_index(0, 0, 0)));
        send_item(deposit_req(32'h003F_8000, 32'h003F_8000, 32'h003F_8000));
        send_item(read_req(cell_index(63, 63, 63)));
        send_item(read_req(cell_index(0, 0, 0)));
        send_item(read_req(cell_index(63, 0, 63)));
        send_item(deposit_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(read_req(cell_index(63, 63, 63)));
        send_item(deposit_req(32'h1234_5678, 32'h0001_8000, 32'hABCD_0001));
        send_item(read_req(cell_index(52, 1, 13)));
        send_item(read_req(cell_index(53, 2, 14)));
        send_item(deposit_req(32'h0005_0000, 32'h0006_0000, 32'h0007_0000));
        send_item(read_req(cell_index(5, 6, 7)));
        send_item(read_req(32'h2AAAA));

        // Zero inverse length: every particle lands whole on the first cell.
        drain_block();
        write_inv(32'h0000_0000);
        send_item(deposit_req($urandom, $urandom, $urandom));
        send_item(deposit_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(read_req(cell_index(0, 0, 0)));

        // Largest inverse length.
        drain_block();
        write_inv(32'hFFFF_FFFF);
        base_x = 32'h0000_0001;
        base_y = 32'h8000_0000;
        base_z = 32'hFFFF_FFFF;
        send_item(deposit_req(base_x, base_y, base_z));
        send_item(read_req(cell_near_base()));

        // Smallest non-zero inverse length: the position becomes the fraction.
        drain_block();
        write_inv(32'h0000_0001);
        send_item(deposit_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(read_req(cell_index(1, 1, 1)));
        send_item(read_req(cell_index(0, 0, 0)));

        // Random segments, each with its own setting and idling pattern.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_block();
            if (seg == 5) begin
                write_inv($urandom);
            end else begin
                write_inv(inv_plan[seg]);
            end
            send_idle_pct = idle_plan[seg % 4];
            stall_pct     = stall_plan[seg % 4];
            base_x        = $urandom;
            base_y        = $urandom;
            base_z        = $urandom;
            // Hold the result side off while items keep coming, so that a
            // waiting result blocks the next read at the input.
            if (seg == 4) begin
                holdoff_req++;
            end
            repeat (SEGMENT_ITEMS) random_item();
        end

        drain_block();
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // The time limit allows for the mesh clear of all 262144 cells after reset.
    initial begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- cic_mass_deposit_3d_unit.f -----
hdl/cicmd_pkg.sv
hdl/cicmd_ctrl.sv
hdl/cicmd_datapath.sv
hdl/cic_mass_deposit_3d_unit.sv
verif/cic_deposit_checker.sv
verif/tb.sv
